// ===== hdl/berdec_pkg.sv =====
// Shared types, constants and helpers of the BER object-identifier decoder.
`default_nettype none
package berdec_pkg;

	// Largest datagram; the room after a byte saturates one below it.
	localparam int DATAGRAM_BYTES = 65536;
	localparam logic [15:0] ROOM_MAX = (DATAGRAM_BYTES - 1 > 65535) ? 16'hFFFF
		: 16'(DATAGRAM_BYTES - 1);

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_TAG = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 8'd1;

	localparam logic [7:0] EXPECTED_TAG_RESET = 8'd6;
	localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_WRONG_TYPE = 3'd1;
	localparam logic [2:0] ERR_INTERRUPTED = 3'd2;
	localparam logic [2:0] ERR_WRONG_LENGTH = 3'd3;
	localparam logic [2:0] ERR_NO_ROOM = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [15:0] bytes_after;
	} in_item_t;

	typedef struct packed {
		logic [63:0] arc_value;
		logic [2:0] error_code;
		logic last_result;
	} out_item_t;

	// Up to two results per request go to the result queue in one cycle.
	typedef struct packed {
		logic v0;
		logic v1;
		out_item_t r0;
		out_item_t r1;
	} push_t;

	// Quotient by 40 of a byte: (b >> 3) / 5 through a multiply by 13/64.
	function automatic logic [2:0] div40(input logic [7:0] b);
		logic [9:0] p;
		p = 10'(b[7:3]) * 10'd13;
		return p[8:6];
	endfunction

	function automatic logic [5:0] mod40(input logic [7:0] b);
		logic [7:0] m;
		logic [7:0] r;
		m = {5'd0, div40(b)} * 8'd40;
		r = b - m;
		return r[5:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/berdec_parser.sv =====
// Input register and per-byte element parser producing up to two results.
`default_nettype none
module berdec_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire berdec_pkg::in_item_t in_data,
	input wire logic space_ok,
	input wire logic [7:0] expected_tag,
	input wire logic [31:0] max_length,
	output berdec_pkg::push_t push
);

	typedef enum logic [2:0] {
		PH_TAG = 3'd0,
		PH_LEN = 3'd1,
		PH_LENX = 3'd2,
		PH_FIRST = 3'd3,
		PH_ARC = 3'd4,
		PH_DROP = 3'd5
	} phase_t;

	localparam logic [32:0] LEN_SAT = 33'h1_0000_0000;

	logic valid_s1;
	berdec_pkg::in_item_t data_s1;
	logic advance;

	phase_t phase_q, phase_d;
	logic [6:0] len_left_q, len_left_d;
	logic [32:0] decl_len_q, decl_len_d;
	logic [31:0] content_left_q, content_left_d;
	logic [63:0] acc_q, acc_d;

	logic [7:0] b;
	logic [15:0] room;
	logic ends;
	logic do_check;
	logic [40:0] len_shift;
	logic [31:0] cl_dec;
	logic [63:0] acc_shift;
	berdec_pkg::push_t res;

	assign advance = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	assign b = data_s1.data_byte;
	assign ends = (data_s1.bytes_after == 16'd0);
	assign room = (data_s1.bytes_after > berdec_pkg::ROOM_MAX) ? berdec_pkg::ROOM_MAX
		: data_s1.bytes_after;
	assign len_shift = {decl_len_q, 8'd0} + {33'd0, b};
	assign cl_dec = content_left_q - 32'd1;
	assign acc_shift = {acc_q[56:0], 7'd0} + {57'd0, b[6:0]};

	always_comb begin
		phase_d = phase_q;
		len_left_d = len_left_q;
		decl_len_d = decl_len_q;
		content_left_d = content_left_q;
		acc_d = acc_q;
		do_check = 1'b0;
		res = '0;

		unique case (phase_q)
			PH_TAG: begin
				if (b != expected_tag) begin
					res.v0 = 1'b1;
					res.r0 = '{64'd0, berdec_pkg::ERR_WRONG_TYPE, 1'b1};
					phase_d = PH_DROP;
				end else if (ends) begin
					res.v0 = 1'b1;
					res.r0 = '{64'd0, berdec_pkg::ERR_INTERRUPTED, 1'b1};
					phase_d = PH_DROP;
				end else begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (!b[7]) begin
					decl_len_d = {25'd0, b};
					do_check = 1'b1;
				end else begin
					decl_len_d = '0;
					if ({9'd0, b[6:0]} > room) begin
						res.v0 = 1'b1;
						res.r0 = '{64'd0, berdec_pkg::ERR_INTERRUPTED, 1'b1};
						phase_d = PH_DROP;
					end else if (b[6:0] == 7'd0) begin
						do_check = 1'b1;
					end else begin
						len_left_d = b[6:0];
						phase_d = PH_LENX;
					end
				end
			end
			PH_LENX: begin
				// Once past 2^32 the length sticks there and fails the check.
				if (decl_len_q < LEN_SAT) begin
					decl_len_d = (len_shift > {8'd0, LEN_SAT}) ? LEN_SAT : len_shift[32:0];
				end
				len_left_d = len_left_q - 7'd1;
				if (len_left_d == 7'd0) begin
					do_check = 1'b1;
				end
			end
			PH_FIRST: begin
				content_left_d = cl_dec;
				res.v0 = 1'b1;
				res.r0 = '{{61'd0, berdec_pkg::div40(b)}, berdec_pkg::ERR_OK, 1'b0};
				res.v1 = 1'b1;
				res.r1 = '{{58'd0, berdec_pkg::mod40(b)}, berdec_pkg::ERR_OK,
					cl_dec == 32'd0};
				acc_d = '0;
				phase_d = (cl_dec == 32'd0) ? PH_DROP : PH_ARC;
			end
			PH_ARC: begin
				acc_d = acc_shift;
				content_left_d = cl_dec;
				if (!b[7]) begin
					res.v0 = 1'b1;
					res.r0 = '{acc_shift, berdec_pkg::ERR_OK, cl_dec == 32'd0};
					acc_d = '0;
					if (cl_dec == 32'd0) begin
						phase_d = PH_DROP;
					end
				end else if (cl_dec == 32'd0) begin
					res.v0 = 1'b1;
					res.r0 = '{64'd0, berdec_pkg::ERR_TRUNCATED, 1'b1};
					phase_d = PH_DROP;
				end
			end
			default: begin
			end
		endcase

		if (do_check) begin
			if (decl_len_d == 33'd0 || decl_len_d > {1'b0, max_length}) begin
				res.v0 = 1'b1;
				res.r0 = '{64'd0, berdec_pkg::ERR_WRONG_LENGTH, 1'b1};
				phase_d = PH_DROP;
			end else if (decl_len_d > {17'd0, room}) begin
				res.v0 = 1'b1;
				res.r0 = '{64'd0, berdec_pkg::ERR_NO_ROOM, 1'b1};
				phase_d = PH_DROP;
			end else begin
				content_left_d = decl_len_d[31:0];
				acc_d = '0;
				phase_d = PH_FIRST;
			end
		end

		// The last byte of a datagram always returns the parser to the tag.
		if (ends) begin
			phase_d = PH_TAG;
			len_left_d = '0;
			decl_len_d = '0;
			content_left_d = '0;
			acc_d = '0;
		end
	end

	always_comb begin
		push = res;
		push.v0 = res.v0 && advance;
		push.v1 = res.v1 && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			len_left_q <= '0;
			decl_len_q <= '0;
			content_left_q <= '0;
			acc_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_left_q <= len_left_d;
			decl_len_q <= decl_len_d;
			content_left_q <= content_left_d;
			acc_q <= acc_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/berdec_out_fifo.sv =====
// Result queue taking up to two results a cycle and giving one a cycle while out_ready is high.
`default_nettype none
module berdec_out_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire berdec_pkg::push_t push,
	output logic space_ok,
	output logic out_valid,
	input wire logic out_ready,
	output berdec_pkg::out_item_t out_data
);

	localparam int DEPTH = berdec_pkg::OUT_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	berdec_pkg::out_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic pop;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic [CNT_W-1:0] n_push;

	assign out_valid = (count_q != '0);
	assign out_data = mem_q[rd_ptr_q];
	assign pop = out_valid && out_ready;
	// Room for two is kept so that any request can be taken.
	assign space_ok = (count_q <= CNT_W'(DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);
	assign n_push = CNT_W'(push.v0) + CNT_W'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ber_oid_tlv_decoder.sv =====
// BER object-identifier element decoder, one datagram byte per request.
// Throughput: one byte per cycle while the result queue has room for two; a first content byte gives two results,
// which leave the result queue one at a time.
// A result is worked out from the registered byte and passes through the result queue before it is offered.
// Reset: asynchronous, clears the parser to expecting a tag byte, empties the
// result queue and loads expected_tag = 6 and max_length = 0xFFFFFFFF.
`default_nettype none
module ber_oid_tlv_decoder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire berdec_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output berdec_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [berdec_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);

	logic [7:0] expected_tag_q;
	logic [31:0] max_length_q;
	logic space_ok;
	berdec_pkg::push_t push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tag_q <= berdec_pkg::EXPECTED_TAG_RESET;
			max_length_q <= berdec_pkg::MAX_LENGTH_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == berdec_pkg::REG_EXPECTED_TAG) begin
				expected_tag_q <= cfg_data[7:0];
			end else if (cfg_index == berdec_pkg::REG_MAX_LENGTH) begin
				max_length_q <= cfg_data;
			end
		end
	end

	berdec_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.space_ok(space_ok),
		.expected_tag(expected_tag_q),
		.max_length(max_length_q),
		.push(push)
	);

	berdec_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.space_ok(space_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

// ===== dv/ber_oid_tb_pkg.sv =====
// Arc predictor and result scoreboard for the BER object-identifier decoder bench.
package ber_oid_tb_pkg;

	typedef enum logic [2:0] {
		ST_TAG,
		ST_LEN,
		ST_LEN_EXT,
		ST_FIRST,
		ST_ARC,
		ST_DROP
	} parse_st_t;

	localparam logic [63:0] LENGTH_CAP = 64'h1_0000_0000;

	class oid_arc_tracker;
		logic [7:0] tag_cfg;
		logic [31:0] max_len_cfg;
		parse_st_t st;
		logic [6:0] len_bytes_left;
		logic [63:0] decl_len;
		logic [31:0] content_left;
		logic [63:0] arc_acc;
		berdec_pkg::out_item_t arcs_due[$];
		int mismatches;

		function new();
			tag_cfg = berdec_pkg::EXPECTED_TAG_RESET;
			max_len_cfg = berdec_pkg::MAX_LENGTH_RESET;
			st = ST_TAG;
			len_bytes_left = '0;
			decl_len = '0;
			content_left = '0;
			arc_acc = '0;
			mismatches = 0;
		endfunction

		function void note_reg(logic [berdec_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
			if (idx == berdec_pkg::REG_EXPECTED_TAG) begin
				tag_cfg = val[7:0];
			end else if (idx == berdec_pkg::REG_MAX_LENGTH) begin
				max_len_cfg = val;
			end
		endfunction

		function void push_arc(logic [63:0] arc, logic [2:0] code, logic last);
			berdec_pkg::out_item_t r;
			r.arc_value = arc;
			r.error_code = code;
			r.last_result = last;
			arcs_due.push_back(r);
		endfunction

		// An error ends the element; the rest of the datagram is dropped.
		function void abort(logic [2:0] code);
			st = ST_DROP;
			push_arc(64'd0, code, 1'b1);
		endfunction

		function void settle_length(logic [63:0] room);
			if (decl_len < 64'd1 || decl_len > {32'd0, max_len_cfg}) begin
				abort(berdec_pkg::ERR_WRONG_LENGTH);
			end else if (decl_len > room) begin
				abort(berdec_pkg::ERR_NO_ROOM);
			end else begin
				content_left = decl_len[31:0];
				arc_acc = '0;
				st = ST_FIRST;
			end
		endfunction

		// Works out the results that one accepted request causes.
		function void note_byte(berdec_pkg::in_item_t it);
			logic [7:0] b;
			logic [63:0] room;
			logic last_byte;
			b = it.data_byte;
			room = {48'd0, it.bytes_after};
			last_byte = (it.bytes_after == 16'd0);
			if (room > {48'd0, berdec_pkg::ROOM_MAX})
				room = {48'd0, berdec_pkg::ROOM_MAX};
			case (st)
			ST_TAG: begin
				if (b != tag_cfg)
					abort(berdec_pkg::ERR_WRONG_TYPE);
				else if (last_byte)
					abort(berdec_pkg::ERR_INTERRUPTED);
				else
					st = ST_LEN;
			end
			ST_LEN: begin
				if (!b[7]) begin
					decl_len = {56'd0, b};
					settle_length(room);
				end else begin
					decl_len = '0;
					if (room < {57'd0, b[6:0]}) begin
						abort(berdec_pkg::ERR_INTERRUPTED);
					end else if (b[6:0] == 7'd0) begin
						settle_length(room);
					end else begin
						len_bytes_left = b[6:0];
						st = ST_LEN_EXT;
					end
				end
			end
			ST_LEN_EXT: begin
				// Once the length passes 32 bits it sticks at the cap.
				if (decl_len < LENGTH_CAP) begin
					decl_len = (decl_len << 8) + {56'd0, b};
					if (decl_len > LENGTH_CAP)
						decl_len = LENGTH_CAP;
				end
				len_bytes_left = len_bytes_left - 7'd1;
				if (len_bytes_left == 7'd0)
					settle_length(room);
			end
			ST_FIRST: begin
				content_left = content_left - 32'd1;
				push_arc(64'(b / 8'd40), berdec_pkg::ERR_OK, 1'b0);
				push_arc(64'(b % 8'd40), berdec_pkg::ERR_OK, content_left == 32'd0);
				arc_acc = '0;
				st = (content_left == 32'd0) ? ST_DROP : ST_ARC;
			end
			ST_ARC: begin
				arc_acc = (arc_acc << 7) + {57'd0, b[6:0]};
				content_left = content_left - 32'd1;
				if (!b[7]) begin
					push_arc(arc_acc, berdec_pkg::ERR_OK, content_left == 32'd0);
					arc_acc = '0;
					if (content_left == 32'd0)
						st = ST_DROP;
				end else if (content_left == 32'd0) begin
					abort(berdec_pkg::ERR_TRUNCATED);
				end
			end
			default: ;
			endcase
			if (last_byte) begin
				st = ST_TAG;
				len_bytes_left = '0;
				decl_len = '0;
				content_left = '0;
				arc_acc = '0;
			end
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_arc(berdec_pkg::out_item_t got);
			berdec_pkg::out_item_t want;
			if (arcs_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, actual arc %0h code %0d last %0b",
					$time, got.arc_value, got.error_code, got.last_result);
				return;
			end
			want = arcs_due.pop_front();
			if (want.arc_value !== got.arc_value)
				report("arc_value", want.arc_value, got.arc_value);
			if (want.error_code !== got.error_code)
				report("error_code", 64'(want.error_code), 64'(got.error_code));
			if (want.last_result !== got.last_result)
				report("last_result", 64'(want.last_result), 64'(got.last_result));
		endfunction
	endclass

endpackage

// ===== dv/tb_ber_oid_tlv_decoder.sv =====
// Top-level bench for the BER object-identifier decoder: stimulus, handshakes and final check.
module tb_ber_oid_tlv_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_ALWAYS = 0;
	localparam int RX_COIN = 1;
	localparam int RX_BURSTY = 2;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 170;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	berdec_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	berdec_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [berdec_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	ber_oid_tb_pkg::oid_arc_tracker tracker = new();
	logic [7:0] dgram[$];
	logic [7:0] cur_tag;
	int burst_left;
	int tx_gap_max;
	int bytes_sent;

	ber_oid_tlv_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("ber_oid_tlv_decoder test failed");
		$finish;
	end

	// Result side: the stall pattern is drawn anew at random from always ready, coin toss and bursty stalls.
	initial begin
		int cyc;
		int rx_mode;
		int stall_left;
		out_ready = 1'b0;
		cyc = 0;
		rx_mode = RX_ALWAYS;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (cyc % 256 == 0)
				rx_mode = $urandom_range(RX_ALWAYS, RX_BURSTY);
			cyc++;
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						stall_left = $urandom_range(0, 7);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_arc(out_data);
	end

	// Called at a falling edge; returns at the falling edge after the request is taken,
	// with in_valid still high.
	task automatic send_byte(input logic [7:0] b, input logic [15:0] room);
		berdec_pkg::in_item_t it;
		int gap;
		it.data_byte = b;
		it.bytes_after = room;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (tx_gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, tx_gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		tracker.note_byte(it);
		@(negedge clk);
	endtask

	// Counts normally run down to zero; a jumbled datagram carries random counts
	// on every byte but the last.
	task automatic send_dgram(input bit jumble, input int counted);
		logic [15:0] room;
		for (int i = 0; i < dgram.size(); i++) begin
			if (i == dgram.size() - 1)
				room = 16'd0;
			else if (jumble)
				room = 16'($urandom);
			else
				room = 16'(dgram.size() - 1 - i);
			send_byte(dgram[i], room);
		end
		bytes_sent += counted;
	endtask

	task automatic send_random_dgram();
		int len;
		int nlen;
		int lmode;
		int cont_pct;
		int extra;
		int counted;
		int keep;
		logic [7:0] b;
		dgram.delete();
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(1, 8);
			dgram.push_back($urandom_range(0, 1) ? cur_tag : 8'($urandom));
			repeat (len - 1) dgram.push_back(8'($urandom));
			send_dgram($urandom_range(0, 3) == 0, len);
			return;
		end
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
		dgram.push_back(cur_tag);
		lmode = $urandom_range(0, 7);
		if (lmode == 0) begin
			// Long form padded with leading zero bytes.
			nlen = $urandom_range(1, 6);
			dgram.push_back(8'h80 | 8'(nlen));
			repeat (nlen - 1) dgram.push_back(8'h00);
			dgram.push_back(8'(len));
		end else if (lmode == 1) begin
			// Long form with a nonzero top byte: far too long, or past 32 bits.
			nlen = $urandom_range(4, 9);
			dgram.push_back(8'h80 | 8'(nlen));
			dgram.push_back(8'($urandom_range(1, 255)));
			repeat (nlen - 1) dgram.push_back(8'($urandom));
		end else begin
			dgram.push_back(8'(len));
		end
		cont_pct = ($urandom_range(0, 4) == 0) ? 97 : $urandom_range(0, 100);
		dgram.push_back(8'($urandom));
		for (int i = 1; i < len; i++) begin
			b = 8'($urandom);
			if (i == len - 1)
				b[7] = ($urandom_range(0, 9) == 0);
			else
				b[7] = ($urandom_range(1, 100) <= cont_pct);
			dgram.push_back(b);
		end
		counted = dgram.size();
		extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (extra) dgram.push_back(8'($urandom));
		if ($urandom_range(0, 9) == 0 && dgram.size() > 2) begin
			keep = $urandom_range(2, dgram.size() - 1);
			while (dgram.size() > keep)
				void'(dgram.pop_back());
			if (counted > keep)
				counted = keep;
		end
		send_dgram($urandom_range(0, 9) == 0, counted);
	endtask

	// Leaves cfg_valid high; the caller lowers it once the last write is taken.
	task automatic cfg_write(input logic [berdec_pkg::CFG_INDEX_W-1:0] idx,
		input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.note_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] tag, input logic [31:0] max_len);
		in_valid <= 1'b0;
		while (tracker.arcs_due.size() != 0)
			@(negedge clk);
		// A byte that causes no result may still be in flight.
		repeat (4) @(negedge clk);
		cfg_write(berdec_pkg::REG_EXPECTED_TAG, {24'd0, tag});
		cfg_write(berdec_pkg::REG_MAX_LENGTH, max_len);
		cfg_valid <= 1'b0;
		cur_tag = tag;
	endtask

	initial begin
		int target;
		int waited;
		berdec_pkg::out_item_t left;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_tag = berdec_pkg::EXPECTED_TAG_RESET;
		burst_left = 0;
		tx_gap_max = 3;
		bytes_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed datagrams under the reset register values.
		dgram = '{8'h30};
		send_dgram(1'b0, 1);
		dgram = '{8'h06};
		send_dgram(1'b0, 1);
		dgram = '{8'h06, 8'h03, 8'hFF, 8'h81, 8'h7F};
		send_dgram(1'b0, 5);
		dgram = '{8'h06, 8'h84};
		send_dgram(1'b0, 2);
		dgram = '{8'h06, 8'h00};
		send_dgram(1'b0, 2);
		dgram = '{8'h06, 8'h80};
		send_dgram(1'b0, 2);
		dgram = '{8'h06, 8'h85, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
		send_dgram(1'b0, 7);
		dgram = '{8'h06, 8'h02, 8'h2B, 8'h81};
		send_dgram(1'b0, 4);
		send_byte(8'h06, 16'hFFFF);
		send_byte(8'h05, 16'h0000);
		// The count claims more bytes than arrive; the element is abandoned.
		send_byte(8'h06, 16'd5);
		send_byte(8'h03, 16'd4);
		send_byte(8'h2B, 16'd0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: set_config(8'h06, 32'hFFFF_FFFF);
			1: set_config(8'h00, 32'd1);
			2: set_config(8'hFF, 32'd12);
			3: set_config(8'($urandom), $urandom_range(1, 40));
			4: set_config(8'h06, $urandom_range(32'hFFFF_FFFF, 1));
			default: set_config(8'h06, $urandom_range(2, 16));
			endcase
			tx_gap_max = (p % 3 == 2) ? 0 : $urandom_range(2, 8);
			target = bytes_sent + ITEMS_PER_PHASE;
			while (bytes_sent < target)
				send_random_dgram();
		end

		in_valid <= 1'b0;
		waited = 0;
		while (tracker.arcs_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		while (tracker.arcs_due.size() != 0) begin
			left = tracker.arcs_due.pop_front();
			tracker.mismatches++;
			$display("%0t: missing result, expected arc %0h code %0d last %0b, actual none",
				$time, left.arc_value, left.error_code, left.last_result);
		end
		if (tracker.mismatches == 0) begin
			$display("ber_oid_tlv_decoder test passed");
		end else begin
			$display("ber_oid_tlv_decoder test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/berdec_pkg.sv
hdl/berdec_parser.sv
hdl/berdec_out_fifo.sv
hdl/ber_oid_tlv_decoder.sv
dv/ber_oid_tb_pkg.sv
dv/tb_ber_oid_tlv_decoder.sv
